[sv/stk_pkg.sv]
// Shared types and constants for the LIFO stack with delete at depth.
// Used by the cell row, the top level and the port checker.
package stk_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // common width for comparing a count or rank against a position
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_DEL  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    // per-beat command broadcast to every cell of the row
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             del;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

endpackage

[sv/stk_cell.sv]
// One storage cell of the stack row; rank 1 is the top of stack.
// Depends on stk_pkg for widths and the command struct.
module stk_cell (
    input  logic                        aclk,
    input  stk_pkg::cell_cmd_t          cmd,
    input  logic [stk_pkg::CNT_W-1:0]   rank,
    input  logic [stk_pkg::DATA_W-1:0]  above_data,
    input  logic [stk_pkg::DATA_W-1:0]  below_data,
    output logic [stk_pkg::DATA_W-1:0]  data
);

    logic [stk_pkg::DATA_W-1:0] data_reg;
    logic [stk_pkg::DATA_W-1:0] data_next;
    logic                       at_or_below_hole;

    // delete removes the word at depth pos; every cell from there down pulls up
    assign at_or_below_hole =
        (stk_pkg::CMP_W'(rank) >= stk_pkg::CMP_W'(cmd.pos));

    always_comb begin
        data_next = data_reg;
        if (cmd.push) begin
            data_next = above_data;
        end else if (cmd.pop || (cmd.del && at_or_below_hole)) begin
            data_next = below_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/stack_with_delete_at_depth.sv]
// Top level of the LIFO stack with delete at depth: cell row, fill count,
// result register. Depends on stk_pkg and stk_cell.
//
// Usage:
//   Input channel s_*: one beat carries a request (push s_push_value, pop,
//   or delete the word at depth s_position, 1 = top). Result channel m_*:
//   exactly one beat per request with the popped/deleted word, a status
//   (ok, overflow or underflow, which also flags a bad position), and the
//   fill count with empty/full flags after the request.
//   The result beat comes in the cycle after its input beat. Throughput is
//   one request per cycle while the receiver keeps up: every cell of the row
//   loads its neighbor or keeps its word in the same cycle, so push, pop and
//   delete all finish together, and the result register frees up as it is read.
//   When the receiver stalls, the result register holds its beat and
//   s_ready drops until it is taken; s_ready is high whenever the result
//   register is empty or being read.
//   Reset (aresetn low at a clock edge) empties the stack and drops
//   m_valid. Stored words are not cleared; entries past the fill are
//   never read.
module stack_with_delete_at_depth (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic signed [stk_pkg::DATA_W-1:0] s_push_value,
    input  logic [stk_pkg::POS_W-1:0]         s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [stk_pkg::DATA_W-1:0] m_out_value,
    output logic [1:0]                        m_status,
    output logic [stk_pkg::CNT_W-1:0]         m_count,
    output logic                              m_empty_res,
    output logic                              m_full_res
);

    localparam int DEPTH = stk_pkg::DEPTH;
    localparam int CNT_W = stk_pkg::CNT_W;
    localparam int CMP_W = stk_pkg::CMP_W;
    localparam int DATA_W = stk_pkg::DATA_W;

    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic [DATA_W-1:0] above_data [DEPTH];
    logic [DATA_W-1:0] below_data [DEPTH];

    stk_pkg::cell_cmd_t cmd;

    logic               accept;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [DATA_W-1:0]  out_value_reg;
    logic [DATA_W-1:0]  out_value_next;
    stk_pkg::status_t   status_reg;
    stk_pkg::status_t   status_next;
    logic [CNT_W-1:0]   out_count_reg;
    logic               empty_reg;
    logic               full_reg;
    logic               is_empty;
    logic               is_full;
    logic               pos_ok;
    logic [DATA_W-1:0]  del_word;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign pos_ok   = (s_position != '0) &&
                      (CMP_W'(s_position) <= CMP_W'(count_reg));

    // word at depth s_position, an AND-OR select over the row
    always_comb begin
        del_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (CMP_W'(k + 1) == CMP_W'(s_position)) begin
                del_word = del_word | cell_data[k];
            end
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.pos        = s_position;
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = stk_pkg::ST_OK;
        case (s_action)
            stk_pkg::ACT_PUSH: begin
                if (is_full) begin
                    status_next = stk_pkg::ST_OVER;
                end else begin
                    cmd.push   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            stk_pkg::ACT_POP: begin
                if (is_empty) begin
                    status_next    = stk_pkg::ST_UNDER;
                    out_value_next = stk_pkg::WORD_MIN;
                end else begin
                    cmd.pop        = accept;
                    out_value_next = cell_data[0];
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            stk_pkg::ACT_DEL: begin
                if (!pos_ok) begin
                    status_next    = stk_pkg::ST_UNDER;
                    out_value_next = stk_pkg::WORD_MIN;
                end else begin
                    cmd.del        = accept;
                    out_value_next = del_word;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_top
                assign above_data[k] = s_push_value;
            end else begin : g_mid
                assign above_data[k] = cell_data[k-1];
            end
            if (k == DEPTH - 1) begin : g_bot
                assign below_data[k] = '0;
            end else begin : g_up
                assign below_data[k] = cell_data[k+1];
            end

            stk_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .rank       (CNT_W'(k + 1)),
                .above_data (above_data[k]),
                .below_data (below_data[k]),
                .data       (cell_data[k])
            );
        end
    endgenerate

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            out_count_reg <= count_next;
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_status    = status_reg;
    assign m_count     = out_count_reg;
    assign m_empty_res = empty_reg;
    assign m_full_res  = full_reg;

endmodule

[sv/stk_checker.sv]
// Port-level checks for the stack top level, bound to every instance.
// Depends on stk_pkg and stack_with_delete_at_depth.
module stk_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [stk_pkg::DATA_W-1:0] m_out_value,
    input logic [1:0]                        m_status,
    input logic [stk_pkg::CNT_W-1:0]         m_count,
    input logic                              m_empty_res,
    input logic                              m_full_res
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_count))
        else $error("result beat changed while stalled");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_empty_res == (m_count == '0)))
        else $error("empty flag disagrees with count");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_full_res == (m_count == stk_pkg::CNT_W'(stk_pkg::DEPTH))))
        else $error("full flag disagrees with count");

    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == stk_pkg::ST_OVER) |-> m_full_res && (m_out_value == 0))
        else $error("overflow reported on a stack that is not full");

    a_under: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == stk_pkg::ST_UNDER) |->
            (m_out_value == stk_pkg::WORD_MIN))
        else $error("underflow beat without most negative word");

endmodule

bind stack_with_delete_at_depth stk_checker u_stk_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_value (m_out_value),
    .m_status    (m_status),
    .m_count     (m_count),
    .m_empty_res (m_empty_res),
    .m_full_res  (m_full_res)
);
